@@ src/ldrom_pkg.sv @@
// ldrom_pkg: shared constants for the library rom with digit address
// kind codes of the input stream, field widths and stream packing positions
// no dependencies
package ldrom_pkg;

    localparam int KIND_W   = 3;
    localparam int DIGIT_W  = 8;
    localparam int LIDX_W   = 13;
    localparam int BYTE_W   = 8;
    localparam int ADR_REG_W = 16;
    localparam int POS_W    = 2;

    // stream data packing, lowest field first
    localparam int S_TDATA_W = 32;
    localparam int OFS_DIGIT = 0;
    localparam int OFS_LIDX  = OFS_DIGIT + DIGIT_W;
    localparam int OFS_LBYTE = OFS_LIDX + LIDX_W;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_LOAD      = 3'd0;
    localparam t_kind KIND_READ_BYTE = 3'd1;
    localparam t_kind KIND_WR_NIB    = 3'd2;
    localparam t_kind KIND_RD_NIB    = 3'd3;
    localparam t_kind KIND_PEEK_HI   = 3'd4;

    localparam logic [BYTE_W-1:0] HI_NIB_MASK = 8'hF0;

endpackage

@@ src/library_rom_with_digit_address.sv @@
// library_rom_with_digit_address: byte rom with a nibble-wide address register, uses ldrom_pkg
// output: load, nibble write, nibble read and unused kinds go straight to the output register;
//   peek and byte read pass through the fetch state, with the registered memory read in between
// one item at a time, plus output stalls; register kinds stay in idle, a peek passes through
//   fetch, a byte read through fetch and then wrap, which wraps the address modulo ROM_SIZE
// reset: synchronous, active low; then a clearing pass over all ROM_SIZE entries zeros the rom
module library_rom_with_digit_address
    import ldrom_pkg::*;
#(
    parameter int ROM_SIZE = 5000
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // digit_word[7:0], load_index[20:8],
                                             // load_byte[28:21], zero [31:29]
    input  logic [KIND_W-1:0]    i_s_tuser,  // kind[2:0]
    input  logic                 i_s_tlast,  // load_last
    // result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [BYTE_W-1:0]    o_m_tdata,  // read_value[7:0]
    output logic [0:0]           o_m_tuser   // has_value[0]
);

    // memory index width, wide enough for any ROM_SIZE in range
    localparam int ADDR_W = (ROM_SIZE > 2) ? $clog2(ROM_SIZE) : 1;
    localparam int WIDE_W = ADR_REG_W + 1;
    localparam logic [WIDE_W-1:0] ROM_LIM = WIDE_W'(ROM_SIZE);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(ROM_SIZE - 1);
    // floor(2^17 / ROM_SIZE): quotient of any 17-bit value is off by at most one
    localparam logic [WIDE_W-1:0] RECIP = WIDE_W'((1 << WIDE_W) / ROM_SIZE);

    // sequencer states
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;
    localparam logic [1:0] ST_WRAP  = 2'd3;

    logic [1:0]            r_state;
    logic [ADDR_W-1:0]     r_clr;

    // architectural registers
    logic [ADR_REG_W-1:0]  r_addr;
    logic [POS_W-1:0]      r_pos;
    logic                  r_last_wr;

    // rom store and its registered read data
    logic [BYTE_W-1:0]     r_rom [ROM_SIZE];
    logic [BYTE_W-1:0]     r_rd_data;

    // per-item context for the memory kinds
    logic                  r_in_range;
    logic                  r_is_peek;
    logic [WIDE_W-1:0]     r_inc;      // address plus one
    logic [2*WIDE_W-1:0]   r_prod;     // r_inc times reciprocal
    logic [WIDE_W-1:0]     r_qn;       // quotient times ROM_SIZE

    // output register
    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_out_data;
    logic                  r_out_has;

    // input fields
    t_kind                 in_kind;
    logic [DIGIT_W-1:0]    in_digit;
    logic [LIDX_W-1:0]     in_lidx;
    logic [BYTE_W-1:0]     in_lbyte;
    logic                  in_acc;
    logic                  out_take;

    // next values at accept
    logic [ADR_REG_W-1:0]  n_addr;
    logic [POS_W-1:0]      n_pos;
    logic                  n_last_wr;
    logic                  n_out_set;
    logic [BYTE_W-1:0]     n_out_data;
    logic                  n_out_has;
    logic                  n_mem_item;
    logic                  n_out_valid;
    logic [POS_W-1:0]      pos_wr;     // position seen by a nibble write
    logic [POS_W-1:0]      pos_rd;     // position seen by a nibble read
    logic [3:0]            nib_in;
    logic [3:0]            nib_out;

    // memory port signals
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_wa;
    logic [BYTE_W-1:0]     mem_wd;
    logic [WIDE_W-1:0]     lidx_wide;
    logic [WIDE_W-1:0]     wrap_diff;
    logic [WIDE_W-1:0]     wrap_res;

    assign in_kind  = i_s_tuser;
    assign in_digit = i_s_tdata[OFS_DIGIT +: DIGIT_W];
    assign in_lidx  = i_s_tdata[OFS_LIDX  +: LIDX_W];
    assign in_lbyte = i_s_tdata[OFS_LBYTE +: BYTE_W];

    // take an item only when idle and the output register is free by the next edge
    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_take   = r_out_valid && i_m_tready;

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_has;

    // direction switch restarts the nibble position
    assign pos_wr = r_last_wr ? r_pos : '0;
    assign pos_rd = r_last_wr ? '0 : r_pos;
    assign nib_in = in_digit[DIGIT_W-1 -: 4];

    // nibble of the address register at the read position, msn first
    always_comb begin
        unique case (pos_rd)
            2'd0:    nib_out = r_addr[15:12];
            2'd1:    nib_out = r_addr[11:8];
            2'd2:    nib_out = r_addr[7:4];
            default: nib_out = r_addr[3:0];
        endcase
    end

    // item decode: register updates and immediate results
    always_comb begin
        n_addr     = r_addr;
        n_pos      = r_pos;
        n_last_wr  = r_last_wr;
        n_out_set  = 1'b1;
        n_out_data = '0;
        n_out_has  = 1'b0;
        n_mem_item = 1'b0;
        unique case (in_kind)
            KIND_LOAD: begin
                if (i_s_tlast) begin
                    n_addr    = '0;
                    n_pos     = '0;
                    n_last_wr = 1'b0;
                end
            end
            KIND_READ_BYTE: begin
                // result comes from the memory; the address wraps later
                n_pos      = pos_rd;
                n_last_wr  = 1'b0;
                n_out_set  = 1'b0;
                n_mem_item = 1'b1;
            end
            KIND_WR_NIB: begin
                unique case (pos_wr)
                    2'd0:    n_addr = {nib_in, r_addr[11:0]};
                    2'd1:    n_addr = {r_addr[15:12], nib_in, r_addr[7:0]};
                    2'd2:    n_addr = {r_addr[15:8], nib_in, r_addr[3:0]};
                    default: n_addr = {r_addr[15:4], nib_in};
                endcase
                n_pos     = pos_wr + POS_W'(1);
                n_last_wr = 1'b1;
            end
            KIND_RD_NIB: begin
                n_pos      = pos_rd + POS_W'(1);
                n_last_wr  = 1'b0;
                n_out_data = {4'h0, nib_out};
                n_out_has  = 1'b1;
            end
            KIND_PEEK_HI: begin
                n_out_set  = 1'b0;
                n_mem_item = 1'b1;
            end
            default: begin
                // unused kinds: empty result, no state change
            end
        endcase
    end

    // output valid: held while stalled, set by an immediate result or a memory fetch
    always_comb begin
        n_out_valid = r_out_valid && !out_take;
        if (r_state == ST_FETCH) begin
            n_out_valid = 1'b1;
        end else if (in_acc && n_out_set) begin
            n_out_valid = 1'b1;
        end
    end

    // memory write port: clearing pass or an in-range load
    assign lidx_wide = WIDE_W'(in_lidx);
    always_comb begin
        if (r_state == ST_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
            mem_wd = '0;
        end else begin
            mem_we = in_acc && (in_kind == KIND_LOAD) && (lidx_wide < ROM_LIM);
            mem_wa = lidx_wide[ADDR_W-1:0];
            mem_wd = in_lbyte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_rom[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_rom[r_addr[ADDR_W-1:0]];
    end

    // address wrap: remainder of r_inc by ROM_SIZE with one correction step
    assign wrap_diff = r_inc - r_qn;
    assign wrap_res  = (wrap_diff >= ROM_LIM) ? (wrap_diff - ROM_LIM) : wrap_diff;

    // payload registers for the memory kinds
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_range <= (WIDE_W'(r_addr) < ROM_LIM);
            r_is_peek  <= (in_kind == KIND_PEEK_HI);
            r_inc      <= WIDE_W'(r_addr) + WIDE_W'(1);
            r_prod     <= (2*WIDE_W)'(WIDE_W'(r_addr) + WIDE_W'(1)) * (2*WIDE_W)'(RECIP);
        end
        if (r_state == ST_FETCH) begin
            r_qn <= WIDE_W'(r_prod[2*WIDE_W-1 -: WIDE_W] * ROM_LIM);
        end
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_addr      <= '0;
            r_pos       <= '0;
            r_last_wr   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == CLR_LAST) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        r_addr    <= n_addr;
                        r_pos     <= n_pos;
                        r_last_wr <= n_last_wr;
                        if (n_mem_item) begin
                            r_state <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH: begin
                    // output register is free here: ready required it at accept
                    r_state <= r_is_peek ? ST_IDLE : ST_WRAP;
                end
                default: begin
                    r_addr  <= wrap_res[ADR_REG_W-1:0];
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FETCH) begin
            r_out_has <= 1'b1;
            if (!r_in_range) begin
                r_out_data <= '0;
            end else if (r_is_peek) begin
                r_out_data <= r_rd_data & HI_NIB_MASK;
            end else begin
                r_out_data <= r_rd_data;
            end
        end else if (in_acc && n_out_set) begin
            r_out_data <= n_out_data;
            r_out_has  <= n_out_has;
        end
    end

    // the address always lands inside the rom after a byte read wraps it
    a_wrap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRAP) |=> (WIDE_W'(r_addr) < ROM_LIM))
        else $error("address out of range after wrap");

    // no item is taken during the clearing pass
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !in_acc)
        else $error("item accepted during rom clear");

    // a memory kind passes through the fetch state before its result shows
    a_mem_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && n_mem_item) |=> (r_state == ST_FETCH) ##1 r_out_valid)
        else $error("memory result not delivered");

    // a transfer never lands while a stalled result sits in the output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> r_out_valid && $stable(r_out_data))
        else $error("pending result overwritten");

endmodule
